// ===== rtl/cacd_pkg.sv =====
// Shared types, codes and lookup helpers for the clock/alarm/countdown display.
// No dependencies; imported by every module of the block.
`default_nettype none

package cacd_pkg;

  // Field widths
  localparam int TPS_W  = 10;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;
  localparam int CDH_W  = 7;
  localparam int FUNC_W = 3;
  localparam int VIEW_W = 2;
  localparam int SEG_W  = 7;
  localparam int EN_W   = 4;
  localparam int DIG_W  = 4;

  // Event codes
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REFRESH = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_CD_LOAD = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_INC_HR  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_INC_MIN = 3'd4;

  // Display views
  localparam logic [VIEW_W-1:0] VIEW_HHMM  = 2'd0;
  localparam logic [VIEW_W-1:0] VIEW_MMSS  = 2'd1;
  localparam logic [VIEW_W-1:0] VIEW_ALARM = 2'd2;
  localparam logic [VIEW_W-1:0] VIEW_CD    = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_TPS      = 3'd0;
  localparam logic [2:0] REG_AL_HOUR  = 3'd1;
  localparam logic [2:0] REG_AL_MIN   = 3'd2;
  localparam logic [2:0] REG_AL_ARMED = 3'd3;
  localparam logic [2:0] REG_CD_HOURS = 3'd4;
  localparam logic [2:0] REG_CD_MINS  = 3'd5;

  localparam logic [TPS_W-1:0] TPS_RESET = 10'd128;

  localparam logic [MIN_W-1:0]  LAST_MIN  = 6'd59;
  localparam logic [HOUR_W-1:0] LAST_HOUR = 5'd23;

  // Digit selects, leftmost first
  localparam logic [EN_W-1:0] EN_D3 = 4'h8;
  localparam logic [EN_W-1:0] EN_D2 = 4'h4;
  localparam logic [EN_W-1:0] EN_D1 = 4'h2;
  localparam logic [EN_W-1:0] EN_D0 = 4'h1;

  // Segment patterns in board wiring order
  localparam logic [SEG_W-1:0] SEG_LUT [10] = '{
    7'h3F, 7'h09, 7'h5E, 7'h5B, 7'h69, 7'h73, 7'h77, 7'h19, 7'h7F, 7'h7B
  };

  typedef struct packed {
    logic [TPS_W-1:0]  tps;
    logic [HOUR_W-1:0] alarm_hour;
    logic [MIN_W-1:0]  alarm_minute;
    logic              alarm_armed;
    logic [CDH_W-1:0]  cd_start_hours;
    logic [MIN_W-1:0]  cd_start_minutes;
  } cfg_t;

  // Current time and countdown, as the display needs them
  typedef struct packed {
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
    logic [CDH_W-1:0]  cd_hours;
    logic [MIN_W-1:0]  cd_minutes;
  } time_t;

  // Status after the event has been applied
  typedef struct packed {
    logic              buzzer;
    logic              cd_running;
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
  } status_t;

  // Tens digit of a value below 128: multiply by 205/2048
  function automatic logic [DIG_W-1:0] tens_of(input logic [CDH_W-1:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [DIG_W-1:0] ones_of(input logic [CDH_W-1:0] v);
    logic [CDH_W-1:0] t;
    t = 7'(tens_of(v)) * 7'd10;
    return DIG_W'(v - t);
  endfunction

  function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] d);
    return (d < 4'd10) ? SEG_LUT[d] : '0;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cacd_regs.sv =====
// APB register file: prescale and alarm/countdown settings.
// Depends on cacd_pkg for register indexes and the cfg_t struct.
`default_nettype none

module cacd_regs (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [4:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output cacd_pkg::cfg_t        cfg_o
);
  import cacd_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tps              <= TPS_RESET;
      cfg_q.alarm_hour       <= '0;
      cfg_q.alarm_minute     <= '0;
      cfg_q.alarm_armed      <= 1'b0;
      cfg_q.cd_start_hours   <= '0;
      cfg_q.cd_start_minutes <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_TPS:      cfg_q.tps              <= pwdata[TPS_W-1:0];
        REG_AL_HOUR:  cfg_q.alarm_hour       <= pwdata[HOUR_W-1:0];
        REG_AL_MIN:   cfg_q.alarm_minute     <= pwdata[MIN_W-1:0];
        REG_AL_ARMED: cfg_q.alarm_armed      <= pwdata[0];
        REG_CD_HOURS: cfg_q.cd_start_hours   <= pwdata[CDH_W-1:0];
        REG_CD_MINS:  cfg_q.cd_start_minutes <= pwdata[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TPS:      prdata = 32'(cfg_q.tps);
      REG_AL_HOUR:  prdata = 32'(cfg_q.alarm_hour);
      REG_AL_MIN:   prdata = 32'(cfg_q.alarm_minute);
      REG_AL_ARMED: prdata = 32'(cfg_q.alarm_armed);
      REG_CD_HOURS: prdata = 32'(cfg_q.cd_start_hours);
      REG_CD_MINS:  prdata = 32'(cfg_q.cd_start_minutes);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/cacd_time.sv =====
// Timekeeping: prescaler, 24-hour clock, countdown and alarm match.
// Depends on cacd_pkg for codes, cfg_t, time_t and status_t.
`default_nettype none

module cacd_time #(
  parameter int PRESCALE_BITS = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          go_i,
  input  wire logic [cacd_pkg::FUNC_W-1:0]   func_i,
  input  cacd_pkg::cfg_t                     cfg_i,
  output cacd_pkg::time_t                    time_o,
  output cacd_pkg::status_t                  status_o
);
  import cacd_pkg::*;

  localparam int CmpW = (PRESCALE_BITS + 1 > TPS_W) ? PRESCALE_BITS + 1 : TPS_W;

  logic [PRESCALE_BITS-1:0] tick_q, tick_d;
  logic [PRESCALE_BITS:0]   tick_next;
  logic [SEC_W-1:0]         sec_q, sec_d;
  logic [MIN_W-1:0]         min_q, min_d;
  logic [HOUR_W-1:0]        hour_q, hour_d;
  logic [CDH_W-1:0]         cdh_q, cdh_d;
  logic [MIN_W-1:0]         cdm_q, cdm_d;
  logic [SEC_W-1:0]         cds_q, cds_d;
  logic                     cda_q, cda_d;
  logic                     sec_done;

  assign tick_next = {1'b0, tick_q} + 1'b1;
  // A prescaler at all ones also closes the second
  assign sec_done  = (CmpW'(tick_next) >= CmpW'(cfg_i.tps)) | (&tick_q);

  always_comb begin
    tick_d = tick_q;
    sec_d  = sec_q;
    min_d  = min_q;
    hour_d = hour_q;
    cdh_d  = cdh_q;
    cdm_d  = cdm_q;
    cds_d  = cds_q;
    cda_d  = cda_q;
    case (func_i)
      FUNC_TICK: begin
        if (sec_done) begin
          tick_d = '0;
          if (sec_q >= LAST_MIN) begin
            sec_d = '0;
            if (min_q >= LAST_MIN) begin
              min_d  = '0;
              hour_d = (hour_q >= LAST_HOUR) ? '0 : hour_q + 1'b1;
            end else begin
              min_d = min_q + 1'b1;
            end
          end else begin
            sec_d = sec_q + 1'b1;
          end
          if (cda_q) begin
            if (cds_q != '0) begin
              cds_d = cds_q - 1'b1;
            end else if (cdm_q != '0) begin
              cdm_d = cdm_q - 1'b1;
              cds_d = LAST_MIN;
            end else if (cdh_q != '0) begin
              cdh_d = cdh_q - 1'b1;
              cdm_d = LAST_MIN;
              cds_d = LAST_MIN;
            end
            if (cdh_d == '0 && cdm_d == '0 && cds_d == '0) begin
              cda_d = 1'b0;
            end
          end
        end else begin
          tick_d = tick_next[PRESCALE_BITS-1:0];
        end
      end
      FUNC_CD_LOAD: begin
        cdh_d = cfg_i.cd_start_hours;
        cdm_d = cfg_i.cd_start_minutes;
        cds_d = '0;
        cda_d = (cfg_i.cd_start_hours != '0) | (cfg_i.cd_start_minutes != '0);
      end
      FUNC_INC_HR:  hour_d = (hour_q >= LAST_HOUR) ? '0 : hour_q + 1'b1;
      FUNC_INC_MIN: min_d  = (min_q >= LAST_MIN) ? '0 : min_q + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      sec_q  <= '0;
      min_q  <= '0;
      hour_q <= '0;
      cdh_q  <= '0;
      cdm_q  <= '0;
      cds_q  <= '0;
      cda_q  <= 1'b0;
    end else if (go_i) begin
      tick_q <= tick_d;
      sec_q  <= sec_d;
      min_q  <= min_d;
      hour_q <= hour_d;
      cdh_q  <= cdh_d;
      cdm_q  <= cdm_d;
      cds_q  <= cds_d;
      cda_q  <= cda_d;
    end
  end

  assign time_o.hours      = hour_q;
  assign time_o.minutes    = min_q;
  assign time_o.seconds    = sec_q;
  assign time_o.cd_hours   = cdh_q;
  assign time_o.cd_minutes = cdm_q;

  assign status_o.buzzer     = cfg_i.alarm_armed & (hour_d == cfg_i.alarm_hour)
                               & (min_d == cfg_i.alarm_minute);
  assign status_o.cd_running = cda_d;
  assign status_o.hours      = hour_d;
  assign status_o.minutes    = min_d;
  assign status_o.seconds    = sec_d;

endmodule

`default_nettype wire

// ===== rtl/cacd_disp.sv =====
// Display multiplexer: digit position, view select and segment lookup.
// Depends on cacd_pkg for view codes, time_t and the segment helpers.
`default_nettype none

module cacd_disp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          go_i,
  input  wire logic [cacd_pkg::FUNC_W-1:0]   func_i,
  input  wire logic [cacd_pkg::VIEW_W-1:0]   view_i,
  input  cacd_pkg::time_t                    time_i,
  input  cacd_pkg::cfg_t                     cfg_i,
  output logic      [cacd_pkg::SEG_W-1:0]    segments_o,
  output logic      [cacd_pkg::EN_W-1:0]     digit_enable_o
);
  import cacd_pkg::*;

  logic [1:0]       pos_q, pos_d;
  logic             refresh;
  logic [CDH_W-1:0] left, right;
  logic [DIG_W-1:0] digit;
  logic [EN_W-1:0]  en;

  assign refresh = (func_i == FUNC_REFRESH);
  assign pos_d   = pos_q + 1'b1;

  always_comb begin
    case (view_i)
      VIEW_HHMM: begin
        left  = CDH_W'(time_i.hours);
        right = CDH_W'(time_i.minutes);
      end
      VIEW_MMSS: begin
        left  = CDH_W'(time_i.minutes);
        right = CDH_W'(time_i.seconds);
      end
      VIEW_ALARM: begin
        left  = CDH_W'(cfg_i.alarm_hour);
        right = CDH_W'(cfg_i.alarm_minute);
      end
      default: begin
        left  = time_i.cd_hours;
        right = CDH_W'(time_i.cd_minutes);
      end
    endcase
  end

  // Position 0 is the rightmost digit; advancing from it wraps to the left
  always_comb begin
    case (pos_d)
      2'd1: begin
        digit = tens_of(left);
        en    = EN_D3;
      end
      2'd2: begin
        digit = ones_of(left);
        en    = EN_D2;
      end
      2'd3: begin
        digit = tens_of(right);
        en    = EN_D1;
      end
      default: begin
        digit = ones_of(right);
        en    = EN_D0;
      end
    endcase
  end

  assign segments_o     = refresh ? seg_of(digit) : '0;
  assign digit_enable_o = refresh ? en : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (go_i && refresh) begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/clock_alarm_countdown_display.sv =====
// Top level of the clock/alarm/countdown display: stream ports, input and result registers.
// Depends on cacd_pkg, cacd_regs, cacd_time and cacd_disp.
//
//   port group   direction   payload
//   s_axis       in          tuser = func, tdata = view
//   m_axis       out         tdata = segments, enable, buzzer, running, h, m, s
//   APB          in/out      six settings registers at 4*i
//
// One transaction per cycle sustained while m_axis_tready is high; an input passes the
// input register, then the event logic into the result register.
// The result register frees as it is taken, so a stalled m_axis holds one result
// and the input register, then s_axis_tready drops.
// Asynchronous active-low reset clears the clock, countdown, prescaler and digit
// position to zero and the settings to their reset values.
`default_nettype none

module clock_alarm_countdown_display #(
  parameter int PRESCALE_BITS = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [1:0] view
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [6:0] segments, [10:7] digit_enable, [11] buzzer, [12] countdown_running,
  // [17:13] clock_hour, [23:18] clock_minute, [29:24] clock_second
  output logic      [31:0] m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import cacd_pkg::*;

  cfg_t              cfg;
  time_t             tm;
  status_t           status;
  logic [SEG_W-1:0]  segs;
  logic [EN_W-1:0]   en;

  logic              in_vld_q;
  logic [FUNC_W-1:0] func_q;
  logic [VIEW_W-1:0] view_q;
  logic              out_vld_q;
  logic [29:0]       out_q;
  logic              advance;

  assign advance       = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      func_q <= s_axis_tuser[FUNC_W-1:0];
      view_q <= s_axis_tdata[VIEW_W-1:0];
    end
    if (advance) begin
      out_q <= {status.seconds, status.minutes, status.hours,
                status.cd_running, status.buzzer, en, segs};
    end
  end

  cacd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cacd_time #(
    .PRESCALE_BITS (PRESCALE_BITS)
  ) u_time (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (advance),
    .func_i   (func_q),
    .cfg_i    (cfg),
    .time_o   (tm),
    .status_o (status)
  );

  cacd_disp u_disp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .go_i           (advance),
    .func_i         (func_q),
    .view_i         (view_q),
    .time_i         (tm),
    .cfg_i          (cfg),
    .segments_o     (segs),
    .digit_enable_o (en)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q};

endmodule

`default_nettype wire

// ===== test/cacd_checker.sv =====
// Scoreboard for the clock/alarm/countdown display: snoops the stream and APB ports,
// predicts every result from its own copy of the clock state and compares field by field.
// Depends on cacd_pkg for widths, event codes, views and register indexes.
module cacd_checker
  import cacd_pkg::*;
#(
  parameter int PRESCALE_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] view
  input  logic [2:0]  s_axis_tuser,   // [2:0] func
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] segments, [10:7] digit_enable, [11] buzzer, [12] countdown_running,
  // [17:13] clock_hour, [23:18] clock_minute, [29:24] clock_second
  input  logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SEG_W-1:0]  segments;
    logic [EN_W-1:0]   digit_enable;
    logic              buzzer;
    logic              running;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } display_out_t;

  // Settings copy
  logic [TPS_W-1:0]  tps_q;
  logic [HOUR_W-1:0] al_hour_q;
  logic [MIN_W-1:0]  al_min_q;
  logic              al_armed_q;
  logic [CDH_W-1:0]  cd_start_h_q;
  logic [MIN_W-1:0]  cd_start_m_q;

  // Clock, countdown and display state
  logic [PRESCALE_BITS-1:0] prescale_q;
  logic [SEC_W-1:0]         sec_q;
  logic [MIN_W-1:0]         min_q;
  logic [HOUR_W-1:0]        hour_q;
  logic [CDH_W-1:0]         cd_h_q;
  logic [MIN_W-1:0]         cd_m_q;
  logic [SEC_W-1:0]         cd_s_q;
  logic                     cd_on_q;
  logic [1:0]               digit_q;

  display_out_t expected_displays[$];
  display_out_t got, want;
  int fail_count = 0;
  int result_count = 0;
  int waiting = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = waiting;

  task automatic report(input string msg);
    if (fail_count < 40) $display("%0t ERROR %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int seen, input int wanted);
    if (seen != wanted)
      report($sformatf("result %0d %s: got %0d expected %0d", result_count, name, seen, wanted));
  endtask

  function automatic logic [SEG_W-1:0] glyph(input int digit);
    case (digit)
      0:       return 7'h3F;
      1:       return 7'h09;
      2:       return 7'h5E;
      3:       return 7'h5B;
      4:       return 7'h69;
      5:       return 7'h73;
      6:       return 7'h77;
      7:       return 7'h19;
      8:       return 7'h7F;
      9:       return 7'h7B;
      default: return '0;   // blank anything above nine
    endcase
  endfunction

  function automatic void roll_second();
    if (sec_q >= LAST_MIN) begin
      sec_q = '0;
      if (min_q >= LAST_MIN) begin
        min_q  = '0;
        hour_q = (hour_q >= LAST_HOUR) ? '0 : hour_q + 1'b1;
      end else begin
        min_q = min_q + 1'b1;
      end
    end else begin
      sec_q = sec_q + 1'b1;
    end
    if (cd_on_q) begin
      // Borrow down; out-of-range minutes or seconds just keep counting down
      if (cd_s_q != '0) begin
        cd_s_q = cd_s_q - 1'b1;
      end else if (cd_m_q != '0) begin
        cd_m_q = cd_m_q - 1'b1;
        cd_s_q = SEC_W'(59);
      end else if (cd_h_q != '0) begin
        cd_h_q = cd_h_q - 1'b1;
        cd_m_q = MIN_W'(59);
        cd_s_q = SEC_W'(59);
      end
      if (cd_h_q == '0 && cd_m_q == '0 && cd_s_q == '0) cd_on_q = 1'b0;
    end
  endfunction

  function automatic display_out_t apply_event(input logic [FUNC_W-1:0] func,
                                               input logic [VIEW_W-1:0] view);
    display_out_t r;
    int left_val, right_val, digit;
    r = '0;
    left_val = 0;
    right_val = 0;
    digit = 0;
    case (func)
      FUNC_TICK: begin
        // Zero ticks per second behaves as one; a full prescaler forces a second
        if (int'(prescale_q) + 1 >= int'(tps_q) || &prescale_q) begin
          prescale_q = '0;
          roll_second();
        end else begin
          prescale_q = prescale_q + 1'b1;
        end
      end
      FUNC_REFRESH: begin
        case (view)
          VIEW_HHMM:  begin left_val = hour_q;    right_val = min_q;     end
          VIEW_MMSS:  begin left_val = min_q;     right_val = sec_q;     end
          VIEW_ALARM: begin left_val = al_hour_q; right_val = al_min_q;  end
          default:    begin left_val = cd_h_q;    right_val = cd_m_q;    end
        endcase
        digit_q = digit_q + 1'b1;
        case (digit_q)
          2'd1:    begin digit = left_val / 10;  r.digit_enable = EN_D3; end
          2'd2:    begin digit = left_val % 10;  r.digit_enable = EN_D2; end
          2'd3:    begin digit = right_val / 10; r.digit_enable = EN_D1; end
          default: begin digit = right_val % 10; r.digit_enable = EN_D0; end
        endcase
        r.segments = glyph(digit);
      end
      FUNC_CD_LOAD: begin
        cd_h_q  = cd_start_h_q;
        cd_m_q  = cd_start_m_q;
        cd_s_q  = '0;
        cd_on_q = (cd_h_q != '0) || (cd_m_q != '0);
      end
      FUNC_INC_HR:  hour_q = (hour_q >= LAST_HOUR) ? '0 : hour_q + 1'b1;
      FUNC_INC_MIN: min_q = (min_q >= LAST_MIN) ? '0 : min_q + 1'b1;
      default: ;
    endcase
    r.buzzer  = al_armed_q && (hour_q == al_hour_q) && (min_q == al_min_q);
    r.running = cd_on_q;
    r.hour    = hour_q;
    r.minute  = min_q;
    r.second  = sec_q;
    return r;
  endfunction

  function automatic void write_setting(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      REG_TPS:      tps_q        = val[TPS_W-1:0];
      REG_AL_HOUR:  al_hour_q    = val[HOUR_W-1:0];
      REG_AL_MIN:   al_min_q     = val[MIN_W-1:0];
      REG_AL_ARMED: al_armed_q   = val[0];
      REG_CD_HOURS: cd_start_h_q = val[CDH_W-1:0];
      REG_CD_MINS:  cd_start_m_q = val[MIN_W-1:0];
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q        = TPS_RESET;
      al_hour_q    = '0;
      al_min_q     = '0;
      al_armed_q   = 1'b0;
      cd_start_h_q = '0;
      cd_start_m_q = '0;
      prescale_q   = '0;
      sec_q        = '0;
      min_q        = '0;
      hour_q       = '0;
      cd_h_q       = '0;
      cd_m_q       = '0;
      cd_s_q       = '0;
      cd_on_q      = 1'b0;
      digit_q      = '0;
      expected_displays.delete();
      waiting      = 0;
    end else begin
      // Retire the older transaction first, then predict the new one
      if (m_axis_tvalid && m_axis_tready) begin
        got.segments     = m_axis_tdata[6:0];
        got.digit_enable = m_axis_tdata[10:7];
        got.buzzer       = m_axis_tdata[11];
        got.running      = m_axis_tdata[12];
        got.hour         = m_axis_tdata[17:13];
        got.minute       = m_axis_tdata[23:18];
        got.second       = m_axis_tdata[29:24];
        if (expected_displays.size() == 0) begin
          report($sformatf("result %0d arrived with no transaction waiting", result_count));
        end else begin
          want = expected_displays.pop_front();
          check_field("segments", got.segments, want.segments);
          check_field("digit_enable", got.digit_enable, want.digit_enable);
          check_field("buzzer", got.buzzer, want.buzzer);
          check_field("countdown_running", got.running, want.running);
          check_field("clock_hour", got.hour, want.hour);
          check_field("clock_minute", got.minute, want.minute);
          check_field("clock_second", got.second, want.second);
        end
        result_count++;
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_displays.push_back(apply_event(s_axis_tuser, s_axis_tdata[VIEW_W-1:0]));
      if (psel && penable && pwrite && pready)
        write_setting(paddr[4:2], pwdata);
      waiting = expected_displays.size();
    end
  end

endmodule

// ===== test/tb_clock_alarm_countdown_display.sv =====
// Testbench top for clock_alarm_countdown_display: clock, reset, APB settings,
// directed and random event streams with idle profiles; cacd_checker does the checking.
// Depends on cacd_pkg, cacd_checker and the block's RTL.
module tb_clock_alarm_countdown_display;
  import cacd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRESCALE_BITS = 10;
  localparam int CLK_HALF      = 5;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 82;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [1:0] view
  logic [2:0]  s_axis_tuser = '0;   // [2:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [6:0] segments, [10:7] digit_enable, [11] buzzer, [12] countdown_running,
  // [17:13] clock_hour, [23:18] clock_minute, [29:24] clock_second
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int send_idle_pct = 14;
  int recv_idle_pct = 68;
  int n_items = 0;
  int n_phases = 0;
  int cycle_count = 0;
  int fail_count;
  int pending;
  logic [HOUR_W-1:0] seen_hour = '0;
  logic [MIN_W-1:0]  seen_minute = '0;

  clock_alarm_countdown_display #(
    .PRESCALE_BITS(PRESCALE_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  cacd_checker #(
    .PRESCALE_BITS(PRESCALE_BITS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Track the displayed time so the alarm can be aimed at it
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      seen_hour   <= m_axis_tdata[17:13];
      seen_minute <= m_axis_tdata[23:18];
    end
  end

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [VIEW_W-1:0] view);
    @(negedge clk_i);
    // Idle cycle by cycle at the sender's rate
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {6'b0, view};
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
  endtask

  // Drop valid and hold off until every result of the phase is back
  task automatic finish_phase();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [FUNC_W-1:0] pick_func();
    int r;
    r = $urandom_range(99);
    if (r < 55) return FUNC_TICK;
    if (r < 80) return FUNC_REFRESH;
    if (r < 81) return FUNC_CD_LOAD;
    if (r < 89) return FUNC_INC_HR;
    if (r < 97) return FUNC_INC_MIN;
    return FUNC_W'($urandom_range(5, 7));
  endfunction

  task automatic program_random_settings();
    int r;
    logic [TPS_W-1:0]  tps;
    logic [HOUR_W-1:0] al_hour;
    logic [MIN_W-1:0]  al_min;
    logic [CDH_W-1:0]  cd_hours;
    logic [MIN_W-1:0]  cd_mins;
    r = $urandom_range(99);
    if (r < 45)      tps = TPS_W'($urandom_range(0, 1));
    else if (r < 70) tps = TPS_W'($urandom_range(2, 6));
    else if (r < 95) tps = TPS_W'($urandom_range(7, 100));
    else             tps = TPS_W'($urandom_range(101, 1023));
    r = $urandom_range(99);
    if (r < 55) begin
      al_hour = seen_hour;
      al_min  = seen_minute + MIN_W'($urandom_range(0, 1));
    end else if (r < 85) begin
      al_hour = HOUR_W'($urandom_range(0, 23));
      al_min  = MIN_W'($urandom_range(0, 59));
    end else begin
      al_hour = HOUR_W'($urandom_range(0, 31));
      al_min  = MIN_W'($urandom_range(0, 63));
    end
    r = $urandom_range(99);
    if (r < 55)      cd_hours = '0;
    else if (r < 75) cd_hours = CDH_W'($urandom_range(1, 2));
    else if (r < 85) cd_hours = CDH_W'(99);
    else             cd_hours = CDH_W'($urandom_range(0, 127));
    r = $urandom_range(99);
    if (r < 40)      cd_mins = MIN_W'(1);
    else if (r < 60) cd_mins = MIN_W'($urandom_range(0, 3));
    else if (r < 85) cd_mins = MIN_W'($urandom_range(0, 59));
    else             cd_mins = MIN_W'($urandom_range(56, 63));
    apb_write(REG_TPS, 32'(tps));
    apb_write(REG_AL_HOUR, 32'(al_hour));
    apb_write(REG_AL_MIN, 32'(al_min));
    apb_write(REG_AL_ARMED, 32'($urandom_range(99) < 75));
    apb_write(REG_CD_HOURS, 32'(cd_hours));
    apb_write(REG_CD_MINS, 32'(cd_mins));
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: digit rotation, a slow tick, unused codes, increments
    repeat (4) send_item(FUNC_REFRESH, VIEW_HHMM);
    send_item(FUNC_TICK, VIEW_HHMM);
    send_item(FUNC_W'(5), VIEW_MMSS);
    send_item(FUNC_W'(6), VIEW_ALARM);
    send_item(FUNC_W'(7), VIEW_CD);
    send_item(FUNC_INC_HR, VIEW_HHMM);
    send_item(FUNC_INC_MIN, VIEW_HHMM);
    finish_phase();
    n_phases++;

    // Zero ticks per second, alarm on the current time, oversized countdown
    apb_write(REG_TPS, 32'd0);
    apb_write(REG_AL_HOUR, 32'd1);
    apb_write(REG_AL_MIN, 32'd1);
    apb_write(REG_AL_ARMED, 32'd1);
    apb_write(REG_CD_HOURS, 32'd127);
    apb_write(REG_CD_MINS, 32'd63);
    send_item(FUNC_CD_LOAD, VIEW_HHMM);
    repeat (4) send_item(FUNC_REFRESH, VIEW_CD);
    repeat (2) send_item(FUNC_REFRESH, VIEW_ALARM);
    repeat (2) send_item(FUNC_TICK, VIEW_HHMM);
    send_item(FUNC_INC_MIN, VIEW_HHMM);
    finish_phase();
    n_phases++;

    // Slowest prescaler, out-of-range alarm, countdown load of zero stops it
    apb_write(REG_TPS, 32'd1023);
    apb_write(REG_AL_HOUR, 32'd31);
    apb_write(REG_AL_MIN, 32'd63);
    apb_write(REG_AL_ARMED, 32'd0);
    apb_write(REG_CD_HOURS, 32'd0);
    apb_write(REG_CD_MINS, 32'd0);
    send_item(FUNC_CD_LOAD, VIEW_HHMM);
    repeat (4) send_item(FUNC_REFRESH, VIEW_ALARM);
    send_item(FUNC_TICK, VIEW_HHMM);
    finish_phase();
    n_phases++;

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       begin send_idle_pct = 14; recv_idle_pct = 68; end
        1:       begin send_idle_pct = 68; recv_idle_pct = 14; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int ph = 0; ph < 5; ph++) begin
        program_random_settings();
        n_phases++;
        // Start the countdown in about half the phases and let it run
        if ($urandom_range(1) == 1) send_item(FUNC_CD_LOAD, VIEW_W'($urandom_range(0, 3)));
        for (int k = 0; k < PHASE_ITEMS; k++)
          send_item(pick_func(), VIEW_W'($urandom_range(0, 3)));
        finish_phase();
      end
    end

    repeat (8) @(negedge clk_i);
    $display("Summary: %0d event transactions over %0d settings phases,", n_items, n_phases);
    $display("  ticks, refreshes of all views, countdown loads, increments and unused codes.");
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
